/* rtl/svpwm_pkg.sv */
// Shared types and constants for the space vector PWM duty calculator.
// No dependencies; every rtl file but svpwm_count refers to this package by scoped name.
`timescale 1ns / 1ps

package svpwm_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_APPLY_GAIN  = 2'd0;
   localparam logic [1:0] CSR_MOD_GAIN    = 2'd1;
   localparam logic [1:0] CSR_SW_PERIOD   = 2'd2;

   // Fixed point constants: sqrt(3) in Q16, unity gain in Q14, 2.0 in Q28.
   localparam logic [16:0] SQRT3_Q16      = 17'd113512;
   localparam logic [15:0] UNITY_GAIN     = 16'd16384;
   localparam logic signed [35:0] TWO_Q28 = 36'sd536870912;

   // Sector codes.
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;
   localparam logic [2:0] SECTOR_6 = 3'd6;

   // Doubled X, Y, Z values in Q28 travelling between stages.
   typedef struct packed {
      logic signed [34:0] x;
      logic signed [34:0] y;
      logic signed [34:0] z;
      logic               zero_ts;
   } xyz_type;

   // Quadrupled on-times in Q28 plus the sector.
   typedef struct packed {
      logic signed [35:0] ta;
      logic signed [35:0] tb;
      logic signed [35:0] tc;
      logic [2:0]         sector;
      logic               zero_ts;
   } times_type;

endpackage

/* rtl/svpwm_xyz.sv */
// Front pipeline: gain scaling, sqrt3 product and X/Y/Z forming.
// Depends on svpwm_pkg.
`timescale 1ns / 1ps

module svpwm_xyz (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [15:0]    alpha,
   input  logic signed [15:0]    beta,
   input  logic [15:0]           gain,
   input  logic                  zero_ts,
   output logic                  out_valid,
   output svpwm_pkg::xyz_type    out_xyz
);

   // Stage 1: scaled inputs u and v (Q28).
   logic               s1_valid_ff;
   logic signed [32:0] u_ff, v_ff, u_in, v_in;
   logic               s1_zero_ff;

   assign u_in = 33'(alpha * $signed({1'b0, gain}));
   assign v_in = 33'(beta * $signed({1'b0, gain}));

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else s1_valid_ff <= in_valid;
      u_ff       <= u_in;
      v_ff       <= v_in;
      s1_zero_ff <= zero_ts;
   end

   // Stage 2: sqrt3 product.
   logic               s2_valid_ff;
   logic signed [50:0] p_ff, p_in;
   logic signed [32:0] v2_ff;
   logic               s2_zero_ff;

   assign p_in = 51'(u_ff * $signed({1'b0, svpwm_pkg::SQRT3_Q16}));

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else s2_valid_ff <= s1_valid_ff;
      p_ff       <= p_in;
      v2_ff      <= v_ff;
      s2_zero_ff <= s1_zero_ff;
   end

   // Stage 3: divide by 65536 toward zero, then form doubled X, Y, Z.
   logic signed [50:0] p_adj;
   logic signed [34:0] s_val;
   logic signed [34:0] v_ext;
   svpwm_pkg::xyz_type xyz_ff, xyz_in;
   logic               s3_valid_ff;

   always_comb begin
      p_adj      = p_ff[50] ? p_ff + 51'sd65535 : p_ff;
      s_val      = 35'(p_adj >>> 16);
      v_ext      = 35'(v2_ff);
      xyz_in.x   = v_ext <<< 1;
      xyz_in.y   = s_val + v_ext;
      xyz_in.z   = v_ext - s_val;
      xyz_in.zero_ts = s2_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else s3_valid_ff <= s2_valid_ff;
      xyz_ff <= xyz_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_xyz   = xyz_ff;

endmodule

/* rtl/svpwm_times.sv */
// Sector decision and on-time table.
// Depends on svpwm_pkg.
`timescale 1ns / 1ps

module svpwm_times (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  svpwm_pkg::xyz_type    in_xyz,
   output logic                  out_valid,
   output svpwm_pkg::times_type  out_times
);

   logic signed [35:0] x, y, z, two;
   logic [2:0]         sector;
   svpwm_pkg::times_type t_in, t_ff;
   logic               valid_ff;

   // Sector from the signs, then the six-case on-time table.
   always_comb begin
      x   = 36'(in_xyz.x);
      y   = 36'(in_xyz.y);
      z   = 36'(in_xyz.z);
      two = svpwm_pkg::TWO_Q28;
      if (y < 0) begin
         if (z < 0) sector = svpwm_pkg::SECTOR_5;
         else sector = (x < 0) ? svpwm_pkg::SECTOR_4 : svpwm_pkg::SECTOR_3;
      end else begin
         if (z > 0) sector = svpwm_pkg::SECTOR_2;
         else sector = (x < 0) ? svpwm_pkg::SECTOR_6 : svpwm_pkg::SECTOR_1;
      end
      t_in.sector  = sector;
      t_in.zero_ts = in_xyz.zero_ts;
      unique case (sector)
         svpwm_pkg::SECTOR_1: begin
            t_in.ta = two - z + x;
            t_in.tb = two + z + x;
            t_in.tc = two + z - x;
         end
         svpwm_pkg::SECTOR_2: begin
            t_in.tb = two + z + y;
            t_in.ta = two - z + y;
            t_in.tc = two - z - y;
         end
         svpwm_pkg::SECTOR_3: begin
            t_in.tb = two + x - y;
            t_in.tc = two - x - y;
            t_in.ta = two - x + y;
         end
         svpwm_pkg::SECTOR_4: begin
            t_in.tc = two - x + z;
            t_in.tb = two + x + z;
            t_in.ta = two + x - z;
         end
         svpwm_pkg::SECTOR_5: begin
            t_in.tc = two - y - z;
            t_in.ta = two + y - z;
            t_in.tb = two + y + z;
         end
         default: begin
            t_in.ta = two + y - x;
            t_in.tc = two - y - x;
            t_in.tb = two - y + x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      t_ff <= t_in;
   end

   assign out_valid = valid_ff;
   assign out_times = t_ff;

endmodule

/* rtl/svpwm_count.sv */
// Converts one quadrupled on-time into a clamped compare count over two stages.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module svpwm_count #(
   parameter int unsigned PERIOD = 6000
) (
   input  logic               clock,
   input  logic signed [35:0] t4,
   output logic [15:0]        count
);

   localparam logic [15:0] PERIOD_C = 16'(PERIOD);

   // Stage 1: clamp negatives, register a saturated magnitude.
   logic [31:0] mag_ff, mag_in;
   always_comb begin
      if (t4 <= 0) mag_in = '0;
      else if (t4 > 36'sh0_FFFF_FFFF) mag_in = 32'hFFFF_FFFF;
      else mag_in = t4[31:0];
   end

   // Stage 2: multiply by PERIOD and shift; magnitudes above 2^32 clamp anyway.
   logic [47:0] prod_ff;
   logic [17:0] c;
   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      prod_ff <= mag_ff * PERIOD_C;
   end

   always_comb begin
      c = prod_ff[47:30];
      count = (c > 18'(PERIOD_C)) ? PERIOD_C : c[15:0];
   end

endmodule

/* rtl/svpwm_duty_calculator_top.sv */
// Top level of the space vector PWM duty calculator.
// Depends on svpwm_pkg, svpwm_xyz, svpwm_times and svpwm_count.
`timescale 1ns / 1ps

// Usage:
//   Write configuration through the csr_ channel (index 0 apply gain, 1 modulation
//   gain, 2 switching period) while no item is in flight; csr_ready is always high.
//   Start a transfer by raising start with req_voltage_alpha/beta; busy stays low,
//   so an item is accepted on every cycle start is high.
//   Each result appears on the rsp_ ports for one cycle with rsp_valid high,
//   once its item has passed through three front stages (gain product,
//   sqrt3 product, X/Y/Z), one sector/table stage and two count stages.
//   Throughput is one item per clock.
//   A zero switching period gives all counts 0 and sector 1.
//   Reset clears the registers to apply gain off, gain 1.0, period 1 and empties
//   the pipeline. The receiver cannot stall; results are never held.
module svpwm_duty_calculator_top #(
   parameter int unsigned PERIOD = 6000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic signed [15:0] req_voltage_alpha,
   input  logic signed [15:0] req_voltage_beta,
   output logic        rsp_valid,
   output logic [15:0] rsp_compare_a,
   output logic [15:0] rsp_compare_b,
   output logic [15:0] rsp_compare_c,
   output logic [2:0]  rsp_sector_number,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers.
   logic        apply_gain_ff;
   logic [15:0] mod_gain_ff;
   logic [15:0] sw_period_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         apply_gain_ff <= 1'b0;
         mod_gain_ff   <= svpwm_pkg::UNITY_GAIN;
         sw_period_ff  <= 16'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            svpwm_pkg::CSR_APPLY_GAIN: apply_gain_ff <= csr_wdata[0];
            svpwm_pkg::CSR_MOD_GAIN:   mod_gain_ff   <= csr_wdata;
            svpwm_pkg::CSR_SW_PERIOD:  sw_period_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [15:0] gain;
   assign gain = apply_gain_ff ? mod_gain_ff : svpwm_pkg::UNITY_GAIN;

   // Front stages.
   logic               xyz_valid;
   svpwm_pkg::xyz_type xyz;
   svpwm_xyz u_xyz (
      .clock(clock), .reset(reset), .in_valid(start),
      .alpha(req_voltage_alpha), .beta(req_voltage_beta), .gain(gain),
      .zero_ts(sw_period_ff == 16'd0),
      .out_valid(xyz_valid), .out_xyz(xyz)
   );

   // Sector and on-times.
   logic                 t_valid;
   svpwm_pkg::times_type times;
   svpwm_times u_times (
      .clock(clock), .reset(reset), .in_valid(xyz_valid), .in_xyz(xyz),
      .out_valid(t_valid), .out_times(times)
   );

   // Count stages, with sector and valid delayed alongside.
   logic [15:0] ca, cb, cc;
   svpwm_count #(.PERIOD(PERIOD)) u_cnt_a (.clock(clock), .t4(times.ta), .count(ca));
   svpwm_count #(.PERIOD(PERIOD)) u_cnt_b (.clock(clock), .t4(times.tb), .count(cb));
   svpwm_count #(.PERIOD(PERIOD)) u_cnt_c (.clock(clock), .t4(times.tc), .count(cc));

   logic [1:0] v_ff;
   logic [2:0] sec_ff [2];
   logic [1:0] zero_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[0], t_valid};
      sec_ff[0]  <= times.sector;
      sec_ff[1]  <= sec_ff[0];
      zero_ff    <= {zero_ff[0], times.zero_ts};
   end

   assign rsp_valid         = v_ff[1];
   assign rsp_compare_a     = zero_ff[1] ? 16'd0 : ca;
   assign rsp_compare_b     = zero_ff[1] ? 16'd0 : cb;
   assign rsp_compare_c     = zero_ff[1] ? 16'd0 : cc;
   assign rsp_sector_number = zero_ff[1] ? svpwm_pkg::SECTOR_1 : sec_ff[1];

endmodule
